// ----- rtl/bsc_pkg.sv -----
// shared types and codes for the banker's safety checker
package bsc_pkg;

	localparam logic [1:0] REQ_AVAIL = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_MAX   = 2'd2;
	localparam logic [1:0] REQ_CHECK = 2'd3;

	localparam logic CFG_PROC_COUNT = 1'b0;
	localparam logic CFG_RES_COUNT  = 1'b1;

	localparam logic [4:0] PROC_COUNT_RESET = 5'd16;
	localparam logic [3:0] RES_COUNT_RESET  = 4'd8;

	typedef struct packed {
		logic load;
		logic commit;
	} bsc_ctrl_t;

	typedef struct packed {
		logic avail_we;
		logic alloc_we;
		logic max_we;
	} bsc_wr_t;

endpackage

// ----- rtl/bsc_ram.sv -----
// generic single-write, registered-read ram
module bsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/bsc_cell.sv -----
// one resource column: available count, allocation and max need columns, work sum
module bsc_cell import bsc_pkg::*; #(
	parameter int IDX        = 0,
	parameter int MAX_PROCS  = 16,
	parameter int MAX_RES    = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  bsc_ctrl_t                                ctrl,
	input  bsc_wr_t                                  wr,
	input  logic [2:0]                               wr_res,
	input  logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] wr_proc,
	input  logic [COUNT_BITS-1:0]                    wr_data,
	input  logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] rd_addr,
	input  logic [$clog2(MAX_RES+1)-1:0]             eff_res,
	input  logic                                     fit_in,
	output logic                                     fit_out
);
	localparam int RW = $clog2(MAX_RES+1);
	localparam int WW = COUNT_BITS + $clog2(MAX_PROCS+1);

	logic                  hit;
	logic                  active;
	logic [COUNT_BITS-1:0] avail_q;
	logic [WW-1:0]         work_q;
	logic [MAX_PROCS-1:0]  alloc_vld_q;
	logic [MAX_PROCS-1:0]  max_vld_q;
	logic                  alloc_vld_s1;
	logic                  max_vld_s1;
	logic [COUNT_BITS-1:0] alloc_rd;
	logic [COUNT_BITS-1:0] max_rd;
	logic [COUNT_BITS-1:0] alloc_d;
	logic [COUNT_BITS-1:0] max_d;
	logic [COUNT_BITS:0]   need;
	logic                  fit_local;

	assign hit    = (int'(wr_res) == IDX);
	assign active = (RW'(IDX) < eff_res);

	bsc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_PROCS)) u_alloc (
		.clk(clk), .we(wr.alloc_we && hit), .waddr(wr_proc), .wdata(wr_data),
		.raddr(rd_addr), .rdata(alloc_rd)
	);

	bsc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_PROCS)) u_max (
		.clk(clk), .we(wr.max_we && hit), .waddr(wr_proc), .wdata(wr_data),
		.raddr(rd_addr), .rdata(max_rd)
	);

	// entries never written since reset read as zero
	assign alloc_d = alloc_vld_s1 ? alloc_rd : '0;
	assign max_d   = max_vld_s1 ? max_rd : '0;

	// negative need always fits
	assign need      = {1'b0, max_d} - {1'b0, alloc_d};
	assign fit_local = need[COUNT_BITS] || (WW'(need[COUNT_BITS-1:0]) <= work_q);
	assign fit_out   = fit_in && (!active || fit_local);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q      <= '0;
			work_q       <= '0;
			alloc_vld_q  <= '0;
			max_vld_q    <= '0;
			alloc_vld_s1 <= 1'b0;
			max_vld_s1   <= 1'b0;
		end else begin
			if (wr.avail_we && hit) begin
				avail_q <= wr_data;
			end
			if (wr.alloc_we && hit) begin
				alloc_vld_q[wr_proc] <= 1'b1;
			end
			if (wr.max_we && hit) begin
				max_vld_q[wr_proc] <= 1'b1;
			end
			alloc_vld_s1 <= alloc_vld_q[rd_addr];
			max_vld_s1   <= max_vld_q[rd_addr];
			if (ctrl.load) begin
				work_q <= active ? WW'(avail_q) : '0;
			end else if (ctrl.commit && active) begin
				work_q <= work_q + WW'(alloc_d);
			end
		end
	end
endmodule

// ----- rtl/bsc_seq.sv -----
// check sequencer: walks processes in passes, tracks finish flags, holds the result
module bsc_seq import bsc_pkg::*; #(
	parameter int MAX_PROCS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     chk_start,
	input  logic [$clog2(MAX_PROCS+1)-1:0]           eff_procs,
	input  logic                                     fit_all,
	output logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] rd_addr,
	output bsc_ctrl_t                                ctrl,
	output logic                                     busy,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     is_safe
);
	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int PW = $clog2(MAX_PROCS+1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [AW-1:0]        iss_q;
	logic                 ev_valid_s1;
	logic [AW-1:0]        ev_idx_s1;
	logic [MAX_PROCS-1:0] done_q;
	logic [PW-1:0]        finished_q;
	logic                 progress_q;
	logic                 result_q;
	logic                 commit;
	logic                 pass_end;
	logic                 run_end;
	logic [PW-1:0]        finished_nx;
	logic                 progress_nx;

	assign commit      = (state_q == ST_RUN) && ev_valid_s1 && !done_q[ev_idx_s1] && fit_all;
	assign pass_end    = ev_valid_s1 && (PW'(ev_idx_s1) == eff_procs - PW'(1));
	assign finished_nx = finished_q + PW'(commit);
	assign progress_nx = progress_q || commit;
	assign run_end     = pass_end && ((finished_nx == eff_procs) || !progress_nx);

	assign rd_addr     = iss_q;
	assign ctrl.load   = chk_start;
	assign ctrl.commit = commit;
	assign busy        = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			ev_valid_s1 <= 1'b0;
			ev_idx_s1   <= '0;
			done_q      <= '0;
			finished_q  <= '0;
			progress_q  <= 1'b0;
			result_q    <= 1'b0;
			out_valid   <= 1'b0;
			is_safe     <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (chk_start) begin
						done_q      <= '0;
						finished_q  <= '0;
						progress_q  <= 1'b0;
						iss_q       <= '0;
						ev_valid_s1 <= 1'b0;
						if (eff_procs == '0) begin
							result_q <= 1'b1;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					// next process read is issued while this one is judged
					ev_valid_s1 <= !run_end;
					ev_idx_s1   <= iss_q;
					if (PW'(iss_q) == eff_procs - PW'(1)) begin
						iss_q <= '0;
					end else begin
						iss_q <= iss_q + AW'(1);
					end
					if (commit) begin
						done_q[ev_idx_s1] <= 1'b1;
					end
					finished_q <= finished_nx;
					progress_q <= pass_end ? 1'b0 : progress_nx;
					if (run_end) begin
						result_q <= (finished_nx == eff_procs);
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						is_safe   <= result_q;
						state_q   <= ST_IDLE;
						iss_q     <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- rtl/bankers_safety_checker.sv -----
// top level: table writes, count registers, row of resource cells and check sequencer
// A write item (available, allocation or max need) is taken while in_ready is
// high and gives no result. A check item holds off further input while the
// sequencer walks the processes, one process per cycle across all resource
// cells at once, in at most P passes (P the effective process count); the
// hold-off ends with the done state (entered at once when P is zero) moving
// the verdict into the output register. While an earlier verdict still
// waits on out_ready, the hold-off lasts until it is taken.
// Work sums update as each process finishes and are seen by the next one.
module bankers_safety_checker import bsc_pkg::*; #(
	parameter int MAX_PROCS  = 16,
	parameter int MAX_RES    = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  proc_index,
	input  logic [2:0]  res_index,
	input  logic [15:0] amount,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_safe
);
	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int PW = $clog2(MAX_PROCS+1);
	localparam int RW = $clog2(MAX_RES+1);

	logic [4:0]      proc_count_q;
	logic [3:0]      res_count_q;
	logic [6:0]      pc_ext;
	logic [5:0]      rc_ext;
	logic [PW-1:0]   eff_procs;
	logic [RW-1:0]   eff_res;
	logic            accept;
	logic            res_ok;
	logic            proc_ok;
	logic            busy;
	bsc_wr_t         wr;
	bsc_ctrl_t       ctrl;
	logic [AW-1:0]   rd_addr;
	logic [MAX_RES:0] fit;

	assign pc_ext    = {2'b0, proc_count_q};
	assign rc_ext    = {2'b0, res_count_q};
	assign eff_procs = (pc_ext > 7'(MAX_PROCS)) ? PW'(MAX_PROCS) : PW'(pc_ext);
	assign eff_res   = (rc_ext > 6'(MAX_RES)) ? RW'(MAX_RES) : RW'(rc_ext);

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;
	assign res_ok   = {3'b0, res_index} < 6'(eff_res);
	assign proc_ok  = {3'b0, proc_index} < 7'(eff_procs);

	assign wr.avail_we = accept && (req_type == REQ_AVAIL) && res_ok;
	assign wr.alloc_we = accept && (req_type == REQ_ALLOC) && res_ok && proc_ok;
	assign wr.max_we   = accept && (req_type == REQ_MAX) && res_ok && proc_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_count_q <= PROC_COUNT_RESET;
			res_count_q  <= RES_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_PROC_COUNT: proc_count_q <= cfg_wdata;
				CFG_RES_COUNT:  res_count_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// fit decision ripples along the row of cells
	assign fit[0] = 1'b1;

	for (genvar j = 0; j < MAX_RES; j++) begin : g_cell
		bsc_cell #(
			.IDX(j), .MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES), .COUNT_BITS(COUNT_BITS)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .wr(wr),
			.wr_res(res_index), .wr_proc(AW'(proc_index)),
			.wr_data(COUNT_BITS'(amount)), .rd_addr(rd_addr), .eff_res(eff_res),
			.fit_in(fit[j]), .fit_out(fit[j+1])
		);
	end

	bsc_seq #(.MAX_PROCS(MAX_PROCS)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.chk_start(accept && (req_type == REQ_CHECK)),
		.eff_procs(eff_procs), .fit_all(fit[MAX_RES]),
		.rd_addr(rd_addr), .ctrl(ctrl), .busy(busy),
		.out_valid(out_valid), .out_ready(out_ready), .is_safe(is_safe)
	);
endmodule
